[hw/rtl/loop_trip_count_solver_unit_assert.svh]
// assertion macros for the loop trip count solver
// no dependencies; included by the top level
`ifndef LOOP_TRIP_COUNT_SOLVER_UNIT_ASSERT_SVH
`define LOOP_TRIP_COUNT_SOLVER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define LTCS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define LTCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ltcs_pkg.sv]
// shared types and codes for the loop trip count solver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ltcs_pkg;

    localparam int TRIP_W = 33;

    // comparison kinds
    localparam logic [2:0] OP_SLT = 3'd0;
    localparam logic [2:0] OP_SLE = 3'd1;
    localparam logic [2:0] OP_SGT = 3'd2;
    localparam logic [2:0] OP_SGE = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;
    localparam logic [2:0] OP_NE  = 3'd5;

    // offset added to the distance before the division
    localparam logic [1:0] OFF_NONE = 2'd0;
    localparam logic [1:0] OFF_DM1  = 2'd1;
    localparam logic [1:0] OFF_D    = 2'd2;

    // decoded comparison rule
    typedef struct packed {
        logic       ok;      // step direction and opcode allow a count
        logic       exact;   // eq / ne: remainder must be zero
        logic       strict;  // count is zero when distance <= 0 (else < 0)
        logic [1:0] offsel;
    } dec_t;

    // control that rides along the divider
    typedef struct packed {
        logic known;
        logic zero;
        logic exact;
    } ctl_t;

endpackage

`default_nettype wire

[hw/rtl/loop_trip_count_solver_unit.sv]
// top level of the loop trip count solver: decode, setup, divider pipeline, output register
// depends on ltcs_pkg, ltcs_decode, ltcs_setup, ltcs_div_step and the assertion header
//
//   channel  | direction | ports
//   ---------+-----------+---------------------------------------------------------
//   s_       | in        | s_valid s_ready s_start_value s_step_amount s_limit_value
//            |           | s_adds_step s_opcode s_exit_when_true
//   m_       | out       | m_valid m_ready m_count_known m_trip_count
//
// one item per cycle sustained while m_ready is high; the divider retires one quotient bit per
// register stage
// synchronous active-low reset clears every stage valid bit; payload registers are not reset
// each stage loads when it is empty or its successor loads, so bubbles close up during a stall
// and an item is only held, never dropped or repeated
`timescale 1ns / 1ps
`default_nettype none
`include "loop_trip_count_solver_unit_assert.svh"

module loop_trip_count_solver_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [31:0]                s_start_value,
    input  wire logic [31:0]                s_step_amount,
    input  wire logic [31:0]                s_limit_value,
    input  wire logic                       s_adds_step,
    input  wire logic [2:0]                 s_opcode,
    input  wire logic                       s_exit_when_true,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_count_known,
    output logic [ltcs_pkg::TRIP_W-1:0]     m_trip_count
);
    import ltcs_pkg::*;

    // operands narrower than the 32-bit fields are sign extended from their low bits
    localparam int EFF_W = (OPERAND_WIDTH < 32) ? OPERAND_WIDTH : 32;
    // dividend and quotient width, also the number of divider stages
    localparam int NW    = EFF_W + 1;

    // decode stage
    logic             dec_valid;
    logic             dec_ready;
    logic [EFF_W:0]   dec_dist;
    logic [EFF_W-1:0] dec_div;
    logic [EFF_W-1:0] dec_dm1;
    dec_t             dec_rule;

    // setup stage
    logic             set_valid;
    logic             set_ready;

    // divider pipeline; index 0 is the setup stage output, index i+1 the output of step i
    logic [NW:0]      stg_valid;
    logic [NW:0]      stg_ready;
    logic [EFF_W-1:0] stg_rem [NW+1];
    logic [EFF_W:0]   stg_rq  [NW+1];
    logic [EFF_W-1:0] stg_div [NW+1];
    ctl_t             stg_ctl [NW+1];

    // output register
    logic                m_valid_reg;
    logic                known_reg, known_next;
    logic [TRIP_W-1:0]   trip_reg, trip_next;
    logic                out_ready;

    // ready chain: a stage takes a new item when empty or when its successor takes its own
    assign out_ready     = !m_valid_reg || m_ready;
    assign stg_ready[NW] = out_ready;
    assign set_ready     = !set_valid || stg_ready[0];
    assign dec_ready     = !dec_valid || set_ready;
    assign s_ready       = dec_ready;

    ltcs_decode #(
        .EFF_W (EFF_W)
    ) u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .load           (dec_ready),
        .start_value    (s_start_value),
        .step_amount    (s_step_amount),
        .limit_value    (s_limit_value),
        .adds_step      (s_adds_step),
        .opcode         (s_opcode),
        .exit_when_true (s_exit_when_true),
        .out_valid      (dec_valid),
        .span           (dec_dist),
        .divisor        (dec_div),
        .divisor_m1     (dec_dm1),
        .dec            (dec_rule)
    );

    ltcs_setup #(
        .EFF_W (EFF_W)
    ) u_setup (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (dec_valid),
        .load        (set_ready),
        .span        (dec_dist),
        .divisor     (dec_div),
        .divisor_m1  (dec_dm1),
        .dec         (dec_rule),
        .out_valid   (set_valid),
        .dividend    (stg_rq[0]),
        .divisor_out (stg_div[0]),
        .ctl         (stg_ctl[0])
    );

    assign stg_valid[0] = set_valid;
    // partial remainder starts at zero
    assign stg_rem[0]   = '0;

    for (genvar i = 0; i < NW; i++) begin : g_div
        // a divider step is ready when empty or when the next stage loads
        assign stg_ready[i] = !stg_valid[i+1] || stg_ready[i+1];

        ltcs_div_step #(
            .EFF_W (EFF_W)
        ) u_step (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .in_valid    (stg_valid[i]),
            .load        (stg_ready[i]),
            .rem_in      (stg_rem[i]),
            .rq_in       (stg_rq[i]),
            .divisor_in  (stg_div[i]),
            .ctl_in      (stg_ctl[i]),
            .out_valid   (stg_valid[i+1]),
            .rem_out     (stg_rem[i+1]),
            .rq_out      (stg_rq[i+1]),
            .divisor_out (stg_div[i+1]),
            .ctl_out     (stg_ctl[i+1])
        );
    end

    // eq / ne need an exact quotient; a loop already past its bound counts zero
    always_comb begin
        known_next = stg_ctl[NW].known && (!stg_ctl[NW].exact || (stg_rem[NW] == '0));
        trip_next  = (known_next && !stg_ctl[NW].zero) ? TRIP_W'(stg_rq[NW]) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= stg_valid[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && stg_valid[NW]) begin
            known_reg <= known_next;
            trip_reg  <= trip_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_count_known = known_reg;
    assign m_trip_count  = trip_reg;

    // an unknown count always carries a zero trip count
    `LTCS_ASSERT_IMPLY(a_unknown_zero, aclk, aresetn, m_valid && !m_count_known, m_trip_count == '0, "unknown count with nonzero trip count")
    // with the output register empty every stage can load, so input is never held off
    `LTCS_ASSERT_IMPLY(a_empty_ready, aclk, aresetn, !m_valid, s_ready, "input stalled while output register empty")
    // an item held at the output stays there until taken
    `LTCS_ASSERT_NEXT(a_out_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_trip_count) && $stable(m_count_known), "held result changed")

endmodule

`default_nettype wire

[hw/rtl/ltcs_decode.sv]
// first stage: operand narrowing, step direction, distance and rule decode
// depends on ltcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ltcs_decode #(
    parameter int EFF_W = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire logic                load,
    input  wire logic [31:0]         start_value,
    input  wire logic [31:0]         step_amount,
    input  wire logic [31:0]         limit_value,
    input  wire logic                adds_step,
    input  wire logic [2:0]          opcode,
    input  wire logic                exit_when_true,
    output logic                     out_valid,
    output logic [EFF_W:0]           span,
    output logic [EFF_W-1:0]         divisor,
    output logic [EFF_W-1:0]         divisor_m1,
    output ltcs_pkg::dec_t           dec
);
    import ltcs_pkg::*;

    logic [EFF_W-1:0] init_w;
    logic [EFF_W-1:0] step_w;
    logic [EFF_W-1:0] bound_w;
    logic [EFF_W:0]   init_x;
    logic [EFF_W:0]   bound_x;
    logic             positive;
    logic             step_nz;

    logic             valid_reg;
    logic [EFF_W:0]   dist_reg, dist_next;
    logic [EFF_W-1:0] div_reg, div_next;
    logic [EFF_W-1:0] dm1_reg, dm1_next;
    dec_t             dec_reg, dec_next;

    assign init_w  = start_value[EFF_W-1:0];
    assign step_w  = step_amount[EFF_W-1:0];
    assign bound_w = limit_value[EFF_W-1:0];
    assign init_x  = {init_w[EFF_W-1], init_w};
    assign bound_x = {bound_w[EFF_W-1], bound_w};

    assign step_nz  = |step_w;
    assign positive = adds_step ? !step_w[EFF_W-1] : step_w[EFF_W-1];

    // distance measured in the direction of travel
    assign dist_next = positive ? (bound_x - init_x) : (init_x - bound_x);
    // magnitude of the step and magnitude minus one, side by side
    assign div_next  = step_w[EFF_W-1] ? (~step_w + EFF_W'(1)) : step_w;
    assign dm1_next  = step_w[EFF_W-1] ? ~step_w : (step_w - EFF_W'(1));

    always_comb begin
        dec_next = '0;
        unique case (opcode)
            OP_SLT: begin
                dec_next.ok     = positive;
                dec_next.strict = 1'b1;
                dec_next.offsel = exit_when_true ? OFF_DM1 : OFF_NONE;
            end
            OP_SLE: begin
                dec_next.ok     = positive;
                dec_next.offsel = OFF_D;
            end
            OP_SGT: begin
                dec_next.ok     = exit_when_true && !positive;
                dec_next.strict = 1'b1;
                dec_next.offsel = OFF_DM1;
            end
            OP_SGE: begin
                dec_next.ok     = exit_when_true && !positive;
                dec_next.offsel = OFF_D;
            end
            OP_EQ: begin
                dec_next.ok     = exit_when_true;
                dec_next.exact  = 1'b1;
            end
            OP_NE: begin
                dec_next.ok     = !exit_when_true;
                dec_next.exact  = 1'b1;
            end
            default: begin
                dec_next.ok     = 1'b0;
            end
        endcase
        dec_next.ok = dec_next.ok && step_nz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            dist_reg <= dist_next;
            div_reg  <= div_next;
            dm1_reg  <= dm1_next;
            dec_reg  <= dec_next;
        end
    end

    assign out_valid  = valid_reg;
    assign span       = dist_reg;
    assign divisor    = div_reg;
    assign divisor_m1 = dm1_reg;
    assign dec        = dec_reg;

endmodule

`default_nettype wire

[hw/rtl/ltcs_setup.sv]
// second stage: zero and known decision, dividend formed from distance and offset
// depends on ltcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ltcs_setup #(
    parameter int EFF_W = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire logic                load,
    input  wire logic [EFF_W:0]      span,
    input  wire logic [EFF_W-1:0]    divisor,
    input  wire logic [EFF_W-1:0]    divisor_m1,
    input  wire ltcs_pkg::dec_t      dec,
    output logic                     out_valid,
    output logic [EFF_W:0]           dividend,
    output logic [EFF_W-1:0]         divisor_out,
    output ltcs_pkg::ctl_t           ctl
);
    import ltcs_pkg::*;

    logic [EFF_W-1:0] offset;
    logic [EFF_W+1:0] sum;
    logic             dist_pos;
    logic             dist_neg;

    logic             valid_reg;
    logic [EFF_W:0]   dvd_reg, dvd_next;
    logic [EFF_W-1:0] div_reg;
    ctl_t             ctl_reg, ctl_next;

    assign dist_neg = span[EFF_W];
    assign dist_pos = !span[EFF_W] && (|span);

    always_comb begin
        unique case (dec.offsel)
            OFF_D:   offset = divisor;
            OFF_DM1: offset = divisor_m1;
            default: offset = '0;
        endcase
    end

    // dividend stays below twice the largest distance, one bit above the operands
    assign sum      = {span[EFF_W], span} + {2'b00, offset};
    assign dvd_next = sum[EFF_W:0];

    always_comb begin
        ctl_next.exact = dec.exact;
        ctl_next.known = dec.ok && (!dec.exact || dist_pos);
        ctl_next.zero  = dec.ok && !dec.exact && (dec.strict ? !dist_pos : dist_neg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            dvd_reg <= dvd_next;
            div_reg <= divisor;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid   = valid_reg;
    assign dividend    = dvd_reg;
    assign divisor_out = div_reg;
    assign ctl         = ctl_reg;

endmodule

`default_nettype wire

[hw/rtl/ltcs_div_step.sv]
// one registered restoring division step: one quotient bit per stage
// depends on ltcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ltcs_div_step #(
    parameter int EFF_W = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire logic                load,
    input  wire logic [EFF_W-1:0]    rem_in,
    input  wire logic [EFF_W:0]      rq_in,
    input  wire logic [EFF_W-1:0]    divisor_in,
    input  wire ltcs_pkg::ctl_t      ctl_in,
    output logic                     out_valid,
    output logic [EFF_W-1:0]         rem_out,
    output logic [EFF_W:0]           rq_out,
    output logic [EFF_W-1:0]         divisor_out,
    output ltcs_pkg::ctl_t           ctl_out
);
    import ltcs_pkg::*;

    logic [EFF_W:0]   trial;
    logic [EFF_W:0]   diff;
    logic             ge;

    logic             valid_reg;
    logic [EFF_W-1:0] rem_reg, rem_next;
    logic [EFF_W:0]   rq_reg, rq_next;
    logic [EFF_W-1:0] div_reg;
    ctl_t             ctl_reg;

    // dividend bits leave at the top of rq, quotient bits enter at the bottom
    assign trial    = {rem_in, rq_in[EFF_W]};
    assign diff     = trial - {1'b0, divisor_in};
    assign ge       = trial >= {1'b0, divisor_in};
    assign rem_next = ge ? diff[EFF_W-1:0] : trial[EFF_W-1:0];
    assign rq_next  = {rq_in[EFF_W-1:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            rem_reg <= rem_next;
            rq_reg  <= rq_next;
            div_reg <= divisor_in;
            ctl_reg <= ctl_in;
        end
    end

    assign out_valid   = valid_reg;
    assign rem_out     = rem_reg;
    assign rq_out      = rq_reg;
    assign divisor_out = div_reg;
    assign ctl_out     = ctl_reg;

endmodule

`default_nettype wire
